@@ rtl/ptca_pkg.sv @@
// Shared types and constants for the pixel tone curve block.
package ptca_pkg;

    // Curve selection codes held in the mode register.
    typedef enum logic [2:0] {
        MODE_EXPOSURE   = 3'd0,
        MODE_BRIGHTNESS = 3'd1,
        MODE_CONTRAST   = 3'd2,
        MODE_BLACKPOINT = 3'd3,
        MODE_TEXTURE    = 3'd4,
        MODE_CLARITY    = 3'd5,
        MODE_SHADOWS    = 3'd6,
        MODE_HIGHLIGHTS = 3'd7
    } mode_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_GAIN     = 2'd1;
    localparam logic [1:0] REG_STRENGTH = 2'd2;

    localparam int CHAN_W   = 8;
    localparam int GAIN_W   = 16;
    localparam int STR_W    = 17;
    localparam int GAIN_ONE = 4096;

    // Numerator, divisor and remainder widths of the per-lane datapath.
    localparam int NUM_W = 34;
    localparam int DEN_W = 23;
    localparam int REM_W = 31;

    // Quotient bits produced by the restoring divider, one per stage.
    localparam int QBITS = 8;
    // Lane stages: operand prep, numerator build, clamp check, divider.
    localparam int LANE_STAGES = 3 + QBITS;

    localparam int LEVEL_TOP = 255;
    localparam int LEVEL_MID = 128;
    localparam int BP_LIMIT  = 254 * 256;
    localparam int SH_DEN    = 255 * 256;
    localparam int CL_DEN    = 25600 * 128;

endpackage

@@ rtl/ptca_lane.sv @@
// One channel lane: evaluates the tone curve and divides it down over pipeline stages.
module ptca_lane
(
    input  logic                                  clk,
    input  logic [ptca_pkg::LANE_STAGES-1:0]      en,
    input  ptca_pkg::mode_t                       mode,
    input  logic [ptca_pkg::GAIN_W-1:0]           gain,
    input  logic signed [ptca_pkg::STR_W-1:0]     strength,
    input  logic [ptca_pkg::CHAN_W-1:0]           chan_in,
    output logic [ptca_pkg::CHAN_W-1:0]           chan_out
);

    localparam int NW = ptca_pkg::NUM_W;
    localparam int DW = ptca_pkg::DEN_W;
    localparam int RW = ptca_pkg::REM_W;
    localparam int QB = ptca_pkg::QBITS;

    // Stage 1: channel value, offset from mid level and clarity weight.
    logic [7:0]          i1_reg;
    logic signed [8:0]   d1_reg;
    logic signed [15:0]  t1_reg;
    logic signed [8:0]   d_c;
    logic [7:0]          ad_c;
    logic signed [15:0]  t_c;

    always_comb
    begin
        d_c  = $signed({1'b0, chan_in}) - 9'sd128;
        ad_c = d_c[8] ? 8'(-d_c) : d_c[7:0];
        t_c  = 16'(d_c * $signed({1'b0, 8'(8'd128 - ad_c)}));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            i1_reg <= chan_in;
            d1_reg <= d_c;
            t1_reg <= t_c;
        end
    end

    // Stage 2: numerator and divisor of the selected curve.
    logic signed [NW-1:0] x2_reg, x_next;
    logic [DW-1:0]        den2_reg, den_next;
    logic signed [NW-1:0] iv, dv, sv, gv, tv, sbv;

    always_comb
    begin
        iv  = NW'($signed({1'b0, i1_reg}));
        dv  = NW'(d1_reg);
        sv  = NW'(strength);
        gv  = NW'($signed({1'b0, gain}));
        tv  = NW'(t1_reg);
        sbv = (sv > NW'(ptca_pkg::BP_LIMIT)) ? NW'(ptca_pkg::BP_LIMIT) : sv;
        x_next   = iv;
        den_next = DW'(1);
        case (mode)
            ptca_pkg::MODE_EXPOSURE, ptca_pkg::MODE_TEXTURE:
            begin
                x_next   = iv * gv;
                den_next = DW'(ptca_pkg::GAIN_ONE);
            end
            ptca_pkg::MODE_BRIGHTNESS:
            begin
                x_next   = (iv <<< 9) + sv;
                den_next = DW'(512);
            end
            ptca_pkg::MODE_CONTRAST:
            begin
                x_next   = dv * gv + NW'(ptca_pkg::LEVEL_MID * ptca_pkg::GAIN_ONE);
                den_next = DW'(ptca_pkg::GAIN_ONE);
            end
            ptca_pkg::MODE_BLACKPOINT:
            begin
                // Non-positive strength leaves the channel unchanged.
                if (sv > 0)
                begin
                    x_next   = (((iv <<< 8) - sbv) <<< 8) - ((iv <<< 8) - sbv);
                    den_next = DW'(NW'(ptca_pkg::SH_DEN) - sbv);
                end
            end
            ptca_pkg::MODE_CLARITY:
            begin
                x_next   = dv * NW'(ptca_pkg::CL_DEN) + tv * sv
                         + NW'(ptca_pkg::LEVEL_MID * ptca_pkg::CL_DEN);
                den_next = DW'(ptca_pkg::CL_DEN);
            end
            ptca_pkg::MODE_SHADOWS:
            begin
                x_next   = iv * NW'(ptca_pkg::SH_DEN)
                         + (NW'(ptca_pkg::LEVEL_TOP) - iv) * sv;
                den_next = DW'(ptca_pkg::SH_DEN);
            end
            default:
            begin
                x_next   = iv * NW'(ptca_pkg::SH_DEN) + iv * sv;
                den_next = DW'(ptca_pkg::SH_DEN);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            x2_reg   <= x_next;
            den2_reg <= den_next;
        end
    end

    // Stage 3: clamp check; in range values go on to the divider.
    logic [RW-1:0]   rem_reg [QB+1];
    logic [DW-1:0]   den_reg [QB+1];
    logic [QB-1:0]   q_reg   [QB+1];
    logic            lo_reg  [QB+1];
    logic            hi_reg  [QB+1];
    logic [RW-1:0]   lim_c;
    logic            lo_c, hi_c;

    always_comb
    begin
        lim_c = (RW'(den2_reg) << 8) - RW'(den2_reg);
        lo_c  = (x2_reg <= 0);
        hi_c  = (x2_reg >= $signed(NW'(lim_c)));
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            rem_reg[0] <= RW'(x2_reg);
            den_reg[0] <= den2_reg;
            q_reg[0]   <= '0;
            lo_reg[0]  <= lo_c;
            hi_reg[0]  <= hi_c;
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        logic [RW-1:0] dsh;
        logic          fit;

        always_comb
        begin
            dsh = RW'(den_reg[j]) << (QB - 1 - j);
            fit = (rem_reg[j] >= dsh);
        end

        always_ff @(posedge clk)
        begin
            if (en[3 + j])
            begin
                rem_reg[j+1] <= fit ? (rem_reg[j] - dsh) : rem_reg[j];
                den_reg[j+1] <= den_reg[j];
                q_reg[j+1]   <= q_reg[j] | (fit ? QB'(1) << (QB - 1 - j) : QB'(0));
                lo_reg[j+1]  <= lo_reg[j];
                hi_reg[j+1]  <= hi_reg[j];
            end
        end
    end

    // Saturated values override the quotient.
    assign chan_out = lo_reg[QB] ? '0 : (hi_reg[QB] ? 8'(ptca_pkg::LEVEL_TOP) : q_reg[QB]);

endmodule

@@ rtl/pixel_tone_curve_adjust_core.sv @@
// Top level: configuration registers, four channel lanes, stage control and output register.
// Usage:
// Pixels enter on the input channel (in_valid/in_ready with red_in, green_in,
// blue_in, alpha_in) and leave on the output channel (out_valid/out_ready with
// red_out, green_out, blue_out, alpha_out). Every transfer in yields one
// transfer out, in order. Each of the four channels runs in its own lane
// through the same tone curve, and the output register merges the lanes.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 is mode, 1 is gain, 2 is strength, index 3 is ignored. The port is
// always ready. Writes must be made only while no pixel is in flight; the
// block itself does not enforce this. An input transfer passes the operand
// prep, numerator build and clamp check stages, the divider stages (one
// quotient bit each) and the output register before out_valid. Throughput
// is one pixel per cycle while the receiver keeps up. When the receiver
// stalls, pipeline bubbles are squeezed out first, so input keeps being
// taken until every stage holds a pixel. Reset clears all stage valid
// flags and sets mode to exposure, gain to 1.0 and strength to 0.
module pixel_tone_curve_adjust_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ptca_pkg::CHAN_W-1:0]        red_in,
    input  logic [ptca_pkg::CHAN_W-1:0]        green_in,
    input  logic [ptca_pkg::CHAN_W-1:0]        blue_in,
    input  logic [ptca_pkg::CHAN_W-1:0]        alpha_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ptca_pkg::CHAN_W-1:0]        red_out,
    output logic [ptca_pkg::CHAN_W-1:0]        green_out,
    output logic [ptca_pkg::CHAN_W-1:0]        blue_out,
    output logic [ptca_pkg::CHAN_W-1:0]        alpha_out,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [ptca_pkg::STR_W-1:0]         cfg_data
);

    localparam int NS = ptca_pkg::LANE_STAGES;
    localparam int CW = ptca_pkg::CHAN_W;

    // Configuration registers.
    ptca_pkg::mode_t                    mode_reg;
    logic [ptca_pkg::GAIN_W-1:0]        gain_reg;
    logic signed [ptca_pkg::STR_W-1:0]  strength_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ptca_pkg::MODE_EXPOSURE;
            gain_reg     <= ptca_pkg::GAIN_W'(ptca_pkg::GAIN_ONE);
            strength_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ptca_pkg::REG_MODE:     mode_reg     <= ptca_pkg::mode_t'(cfg_data[2:0]);
                ptca_pkg::REG_GAIN:     gain_reg     <= cfg_data[ptca_pkg::GAIN_W-1:0];
                ptca_pkg::REG_STRENGTH: strength_reg <= $signed(cfg_data);
                default:                ;
            endcase
        end
    end

    // Stage control: a stage moves when it is empty or the next one moves.
    logic [NS-1:0] v_reg;
    logic [NS:0]   take;

    always_comb
    begin
        take[NS] = !out_valid || out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            take[k] = !v_reg[k] || take[k+1];
        end
    end

    assign in_ready = take[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (take[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (take[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (take[NS])
            begin
                out_valid <= v_reg[NS-1];
            end
        end
    end

    // Four lanes, one per channel.
    logic [CW-1:0] lane_in  [4];
    logic [CW-1:0] lane_out [4];

    assign lane_in[0] = red_in;
    assign lane_in[1] = green_in;
    assign lane_in[2] = blue_in;
    assign lane_in[3] = alpha_in;

    for (genvar n = 0; n < 4; n++)
    begin : g_lane
        ptca_lane u_lane
        (
            .clk      (clk),
            .en       (take[NS-1:0]),
            .mode     (mode_reg),
            .gain     (gain_reg),
            .strength (strength_reg),
            .chan_in  (lane_in[n]),
            .chan_out (lane_out[n])
        );
    end

    // Output register merges the lane results into one pixel.
    always_ff @(posedge clk)
    begin
        if (take[NS])
        begin
            red_out   <= lane_out[0];
            green_out <= lane_out[1];
            blue_out  <= lane_out[2];
            alpha_out <= lane_out[3];
        end
    end

endmodule
